// ===== rtl/core/tcw_pkg.sv =====
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

  // Screen geometry.
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int SIZE   = ROWS * COLS;
  localparam int CELL_W = $clog2(SIZE);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);

  // The mark spans one cell before zero up to a tab run past the end.
  localparam int MARK_W = CELL_W + 2;
  // A relative move sums the cursor, a scaled row step and a column step.
  localparam int MOVE_W = CELL_W + 6;

  // Reciprocal of COLS used to split a cell index into row and column.
  localparam int RECIP_SH = 2 * CELL_W;
  localparam int PROD_W   = CELL_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((2 ** RECIP_SH) / COLS);

  // Field widths.
  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int TROW_W    = 5;
  localparam int TCOL_W    = 7;
  localparam int DROW_W    = 6;
  localparam int DCOL_W    = 8;
  localparam int CUR_ROW_W = 5;
  localparam int CUR_COL_W = 7;
  localparam int TAB_W     = 5;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH    = 1'd1;

  // Register reset values.
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [TAB_W-1:0]  TAB_WIDTH_RST    = 5'd4;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE = 2'd2;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  // One screen cell: attribute in the upper byte.
  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } tcw_cell_t;

  // One input item.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [CHAR_W-1:0]        character;
    logic [ATTR_W-1:0]        attribute;
    logic                     at_position;
    logic [TROW_W-1:0]        target_row;
    logic [TCOL_W-1:0]        target_col;
    logic signed [DROW_W-1:0] delta_row;
    logic signed [DCOL_W-1:0] delta_col;
  } tcw_item_t;

  // One result item.
  typedef struct packed {
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic                 scrolled;
  } tcw_result_t;

  // Screen memory access: one write and one read port.
  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] waddr;
    tcw_cell_t         wdata;
    logic              re;
    logic [CELL_W-1:0] raddr;
  } tcw_mem_req_t;

  // Request to split a cell index into row and column.
  typedef struct packed {
    logic              start;
    logic [CELL_W-1:0] cell_idx;
  } tcw_split_req_t;

  // Row and column of the last split, with a done pulse.
  typedef struct packed {
    logic             done;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tcw_split_rsp_t;

endpackage

// ===== rtl/core/tcw_screen_ram.sv =====
// Screen cell memory with one write port and one registered read port.
module tcw_screen_ram (
  input  logic                 clk_i,
  input  tcw_pkg::tcw_mem_req_t req_i,
  output tcw_pkg::tcw_cell_t   rdata_o
);
  import tcw_pkg::*;

  tcw_cell_t mem [SIZE];
  tcw_cell_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcw_cell_split.sv =====
// Two-stage unit that turns a cell index into a row and a column.
module tcw_cell_split (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcw_pkg::tcw_split_req_t req_i,
  output tcw_pkg::tcw_split_rsp_t rsp_o
);
  import tcw_pkg::*;

  logic              v1_q, v2_q;
  logic [CELL_W-1:0] x_q;
  logic [PROD_W-1:0] prod_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  quot;
  logic [CELL_W:0]   rem;

  // First stage: multiply by the reciprocal of the row length.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.cell_idx;
      prod_q <= {{RECIP_SH{1'b0}}, req_i.cell_idx} * {{CELL_W{1'b0}}, RECIP};
    end
  end

  // Second stage: the estimate is low by at most one, so one correction step.
  always_comb begin
    quot = prod_q[RECIP_SH +: ROW_W];
    rem  = (CELL_W + 1)'(x_q) - (CELL_W + 1)'(quot * COLS);
    if (rem >= (CELL_W + 1)'(COLS)) begin
      row_d = quot + ROW_W'(1);
      col_d = COL_W'(rem - (CELL_W + 1)'(COLS));
    end else begin
      row_d = quot;
      col_d = COL_W'(rem);
    end
  end

  // Row and column hold the cursor position between splits; reset is top left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      row_q <= '0;
      col_q <= '0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
      if (v1_q) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  assign rsp_o.done = v2_q;
  assign rsp_o.row  = row_q;
  assign rsp_o.col  = col_q;

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// Sequencer that works each item: it writes and reads the screen memory and moves the cursor.
module tcw_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  tcw_pkg::tcw_item_t              item_i,
  input  logic [tcw_pkg::ATTR_W-1:0]      default_attr_i,
  input  logic [tcw_pkg::TAB_W-1:0]       tab_width_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output tcw_pkg::tcw_result_t            res_o,
  output tcw_pkg::tcw_mem_req_t           mem_req_o,
  input  tcw_pkg::tcw_cell_t              mem_rdata_i,
  output tcw_pkg::tcw_split_req_t         split_req_o,
  input  tcw_pkg::tcw_split_rsp_t         split_rsp_i
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_POST,
    ST_SCR_PRIME,
    ST_SCROLL,
    ST_READ,
    ST_SPLIT,
    ST_WAIT,
    ST_RESP
  } state_e;

  state_e                   state_q, state_d;
  tcw_item_t                item_q, item_d;
  logic [CELL_W-1:0]        cursor_q, cursor_d;
  logic signed [MARK_W-1:0] mark_q, mark_d;
  logic [CELL_W-1:0]        cnt_q, cnt_d;
  logic [CELL_W:0]          tab_addr_q, tab_addr_d;
  logic [TAB_W-1:0]         tab_left_q, tab_left_d;
  logic [CHAR_W-1:0]        cell_char_q, cell_char_d;
  logic [ATTR_W-1:0]        cell_attr_q, cell_attr_d;
  logic                     scrolled_q, scrolled_d;

  logic [ATTR_W-1:0]        attr_sel;
  logic                     tgt_ok;
  logic [CELL_W-1:0]        tgt_cell;
  logic [CELL_W-1:0]        pos;
  logic signed [MARK_W-1:0] pos_s;
  logic [ROW_W-1:0]         prow;
  logic signed [MOVE_W-1:0] np;
  logic signed [MARK_W-1:0] nxt;
  logic signed [MARK_W-1:0] nxt_up;
  logic signed [MARK_W-1:0] mark_up;

  // Operands decoded from the held item.
  always_comb begin
    attr_sel = (item_q.attribute == '0) ? default_attr_i : item_q.attribute;
    tgt_ok   = (32'(item_q.target_row) < ROWS) && (32'(item_q.target_col) < COLS);
    tgt_cell = CELL_W'(item_q.target_row * COLS + item_q.target_col);
    pos      = item_q.at_position ? tgt_cell : cursor_q;
    pos_s    = signed'({2'b00, pos});
    prow     = item_q.at_position ? ROW_W'(item_q.target_row) : split_rsp_i.row;
    np       = MOVE_W'(signed'({1'b0, cursor_q})) + MOVE_W'(item_q.delta_row * COLS)
             + MOVE_W'(item_q.delta_col);
    // The mark never sits below one cell before zero, so the cursor is never negative.
    nxt      = mark_q + MARK_W'(1);
    nxt_up   = MARK_W'(nxt - COLS);
    mark_up  = MARK_W'(mark_q - COLS);
    if (nxt_up >= SIZE) begin
      nxt_up = MARK_W'(SIZE - 1);
    end
    if (mark_up >= SIZE) begin
      mark_up = MARK_W'(SIZE - 1);
    end
  end

  // Next state and memory accesses. Each access completes before the next
  // step reads, so no two accesses to one cell overlap.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cursor_d    = cursor_q;
    mark_d      = mark_q;
    cnt_d       = cnt_q;
    tab_addr_d  = tab_addr_q;
    tab_left_d  = tab_left_q;
    cell_char_d = cell_char_q;
    cell_attr_d = cell_attr_q;
    scrolled_d  = scrolled_q;
    mem_req_o   = '0;
    split_req_o = '0;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;

    case (state_q)
      // Zero the whole screen after reset, one cell per cycle.
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q;
        if (32'(cnt_q) == SIZE - 1) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CELL_W'(1);
        end
      end

      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d      = item_i;
          cell_char_d = '0;
          cell_attr_d = '0;
          scrolled_d  = 1'b0;
          state_d     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (item_q.mode)
          MODE_PUT: begin
            if (item_q.at_position && !tgt_ok) begin
              state_d = ST_RESP;
            end else begin
              state_d = ST_POST;
              case (item_q.character)
                CH_NEWLINE: begin
                  mark_d = MARK_W'(prow * COLS + (COLS - 1));
                end
                CH_BACKSPACE: begin
                  // A mark before cell zero writes nothing and stays put.
                  if (!mark_q[MARK_W-1]) begin
                    mem_req_o.we    = 1'b1;
                    mem_req_o.waddr = CELL_W'(mark_q);
                    mem_req_o.wdata = '{attr: attr_sel, chr: CH_BLANK};
                    mark_d          = mark_q - MARK_W'(1);
                  end
                end
                CH_TAB: begin
                  tab_addr_d = {1'b0, pos};
                  tab_left_d = tab_width_i;
                  mark_d     = pos_s + MARK_W'(tab_width_i) - MARK_W'(1);
                  state_d    = ST_TAB;
                end
                default: begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = pos;
                  mem_req_o.wdata = '{attr: attr_sel, chr: item_q.character};
                  mark_d          = pos_s;
                end
              endcase
            end
          end
          MODE_READ: begin
            if (tgt_ok) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = tgt_cell;
              state_d         = ST_READ;
            end else begin
              state_d = ST_RESP;
            end
          end
          MODE_MOVE: begin
            if ((np >= 0) && (np < SIZE)) begin
              cursor_d = CELL_W'(np);
            end
            state_d = ST_SPLIT;
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end

      // Tab run: one blank per cycle, cells past the screen end are dropped.
      ST_TAB: begin
        if (tab_left_q != '0) begin
          if (32'(tab_addr_q) < SIZE) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = CELL_W'(tab_addr_q);
            mem_req_o.wdata = '{attr: attr_sel, chr: CH_BLANK};
          end
          tab_addr_d = tab_addr_q + (CELL_W + 1)'(1);
          tab_left_d = tab_left_q - TAB_W'(1);
        end else begin
          state_d = ST_POST;
        end
      end

      // Advance the cursor past the mark, scrolling once at the screen end.
      ST_POST: begin
        if (nxt >= SIZE) begin
          cursor_d   = CELL_W'(nxt_up);
          mark_d     = mark_up;
          scrolled_d = 1'b1;
          state_d    = ST_SCR_PRIME;
        end else begin
          cursor_d = CELL_W'(nxt);
          state_d  = ST_SPLIT;
        end
      end

      // Fetch the first cell of the second row.
      ST_SCR_PRIME: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = CELL_W'(COLS);
        cnt_d           = '0;
        state_d         = ST_SCROLL;
      end

      // Copy each cell one row up while fetching the next; zero the last row.
      ST_SCROLL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q;
        mem_req_o.wdata = (32'(cnt_q) < SIZE - COLS) ? mem_rdata_i : '0;
        if (32'(cnt_q) + 1 + COLS < SIZE) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = CELL_W'(32'(cnt_q) + 1 + COLS);
        end
        if (32'(cnt_q) == SIZE - 1) begin
          cnt_d   = '0;
          state_d = ST_SPLIT;
        end else begin
          cnt_d = cnt_q + CELL_W'(1);
        end
      end

      ST_READ: begin
        cell_char_d = mem_rdata_i.chr;
        cell_attr_d = mem_rdata_i.attr;
        state_d     = ST_RESP;
      end

      ST_SPLIT: begin
        split_req_o.start    = 1'b1;
        split_req_o.cell_idx = cursor_q;
        state_d              = ST_WAIT;
      end

      ST_WAIT: begin
        if (split_rsp_i.done) begin
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cursor_q    <= '0;
      mark_q      <= '0;
      cnt_q       <= '0;
      tab_left_q  <= '0;
      scrolled_q  <= 1'b0;
      cell_char_q <= '0;
      cell_attr_q <= '0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      mark_q      <= mark_d;
      cnt_q       <= cnt_d;
      tab_left_q  <= tab_left_d;
      scrolled_q  <= scrolled_d;
      cell_char_q <= cell_char_d;
      cell_attr_q <= cell_attr_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    tab_addr_q <= tab_addr_d;
  end

  assign res_o.cursor_row = CUR_ROW_W'(split_rsp_i.row);
  assign res_o.cursor_col = CUR_COL_W'(split_rsp_i.col);
  assign res_o.cell_char  = cell_char_q;
  assign res_o.cell_attr  = cell_attr_q;
  assign res_o.scrolled   = scrolled_q;

endmodule

// ===== rtl/core/text_console_writer_unit.sv =====
// Top level of the text console writer: stream ports, registers and output stage.
//
// The console keeps a 25 x 80 screen of character and attribute cells in one
// memory, with a cursor and a mark for the last cell written. Each transaction on
// the slave stream carries one command (put character, read cell or move cursor);
// each command produces exactly one transaction on the master stream with the
// cursor position, the read cell and a scroll flag.
// The configuration channel writes the default attribute (index 0) and the tab
// width (index 1); it is always ready.
// A put passes the memory write, the cursor update and the two-stage row/column
// split of the cursor; a move passes only the split, a read waits on the
// registered memory read and an ignored command goes straight to the result. A
// tab writes its blanks before the cursor update; a scroll rewrites every cell.
// One command is in work at a time; a finished result waits in the output
// register while the next command is taken, so a stalled receiver blocks
// the input only once a second result is ready.
// After reset the screen is cleared to zero by a pass over every cell, during
// which the slave stream is not ready; configuration writes are taken as ever.
module text_console_writer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // character, attribute, at_position, target_row, target_col, delta_row, delta_col
  input  logic [tcw_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // mode
  input  logic [tcw_pkg::MODE_W-1:0]            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // cursor_row, cursor_col, cell_char, cell_attr, scrolled
  output logic [tcw_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] default_attr_q;
  logic [TAB_W-1:0]  tab_width_q;
  tcw_item_t         item;
  logic              res_valid;
  logic              res_ready;
  tcw_result_t       res;
  tcw_mem_req_t      mem_req;
  tcw_cell_t         mem_rdata;
  tcw_split_req_t    split_req;
  tcw_split_rsp_t    split_rsp;
  logic              out_valid_q;
  tcw_result_t       out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= DEFAULT_ATTR_RST;
      tab_width_q    <= TAB_WIDTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEFAULT_ATTR: default_attr_q <= cfg_data_i;
        REG_TAB_WIDTH:    tab_width_q    <= cfg_data_i[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction.
  assign item.mode        = s_axis_tuser;
  assign item.character   = s_axis_tdata[7:0];
  assign item.attribute   = s_axis_tdata[15:8];
  assign item.at_position = s_axis_tdata[16];
  assign item.target_row  = s_axis_tdata[21:17];
  assign item.target_col  = s_axis_tdata[28:22];
  assign item.delta_row   = s_axis_tdata[34:29];
  assign item.delta_col   = s_axis_tdata[42:35];

  tcw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s_axis_tvalid),
    .item_ready_o   (s_axis_tready),
    .item_i         (item),
    .default_attr_i (default_attr_q),
    .tab_width_i    (tab_width_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .split_req_o    (split_req),
    .split_rsp_i    (split_rsp)
  );

  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tcw_cell_split u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (split_req),
    .rsp_o  (split_rsp)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.scrolled, out_q.cell_attr, out_q.cell_char,
                          out_q.cursor_col, out_q.cursor_row};

endmodule

// ===== rtl/core/tcw_checker.sv =====
// Port-level checks of the text console writer and their binding to the top level.
module tcw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [tcw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input logic [tcw_pkg::MODE_W-1:0]         s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tcw_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The clearing pass blocks the input right after reset.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input taken during the clearing pass");

  // Commands are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in work");

  // A scroll always leaves the cursor on the last row.
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[28] |-> 32'(m_axis_tdata[4:0]) == ROWS - 1)
    else $error("scroll reported with cursor off the last row");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);
